>>> rtl/mmmr_pkg.sv
package mmmr_pkg;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_STEP  = 5'b00100,
      ST_APPLY = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // which quotient the divider is working on
   typedef enum logic [1:0] {
      DV_Q   = 2'b01,
      DV_CAP = 2'b10
   } div_sel_type;

endpackage

>>> rtl/min_modular_multiple_range_unit.sv
// each half step: zero test, divide for q, divide for cap, apply; a done state delivers
// a request needs up to about 2*WORD_BITS half steps (euclid-like reduction)
// throughput: one request at a time; the shared bit-serial divider sets the rate
// reset: synchronous, active high; clears the sequencer and the result valid
module min_modular_multiple_range_unit #(
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_modulus,
   input  logic [31:0] req_multiplier,
   input  logic [31:0] req_span,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_min_forward_rem,
   output logic [31:0] rsp_forward_index,
   output logic [31:0] rsp_min_backward_rem,
   output logic [31:0] rsp_backward_index,
   output logic        rsp_input_error
);
   import mmmr_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int CW = $clog2(W + 1);

   state_type      state_ff, state_in;
   div_sel_type    sel_ff, sel_in;
   logic [W-1:0]   l_ff, l_in, r_ff, r_in, x_ff, x_in, y_ff, y_in, n_ff, n_in;
   logic           side_ff, side_in;   // 0: reduce r by l, 1: reduce l by r
   logic [W-1:0]   q_ff, q_in;
   // shared restoring divider
   logic [W-1:0]   dq_ff, dq_in, dd_ff, dd_in;
   logic [W:0]     rem_ff, rem_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   // product register for qeff times lesser
   logic [2*W-1:0] prod_ff, prod_in;
   logic           fin_ff, fin_in;
   logic           out_v_ff, out_v_in;
   logic [W-1:0]   o_l_ff, o_l_in, o_x_ff, o_x_in, o_r_ff, o_r_in, o_y_ff, o_y_in;
   logic           o_e_ff, o_e_in;

   logic [W-1:0]   m_w, a_w, n_w;
   logic [W:0]     trial;
   logic [W-1:0]   big, lesser, bigi, smalli, qeff;
   logic           capped;

   assign m_w = W'(req_modulus);
   assign a_w = W'(req_multiplier);
   assign n_w = W'(req_span);

   assign big    = side_ff ? l_ff : r_ff;
   assign lesser = side_ff ? r_ff : l_ff;
   assign bigi   = side_ff ? x_ff : y_ff;
   assign smalli = side_ff ? y_ff : x_ff;
   assign trial  = {rem_ff[W-1:0], dq_ff[W-1]} - {1'b0, dd_ff};
   assign capped = q_ff > dq_ff;   // dq_ff holds cap once the second division ends
   assign qeff   = capped ? dq_ff : q_ff;

   assign req_stall = (state_ff != ST_IDLE) || out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_min_forward_rem  = 32'(o_l_ff);
   assign rsp_forward_index    = 32'(o_x_ff);
   assign rsp_min_backward_rem = 32'(o_r_ff);
   assign rsp_backward_index   = 32'(o_y_ff);
   assign rsp_input_error      = o_e_ff;

   always_comb begin
      state_in = state_ff; sel_in = sel_ff;
      l_in = l_ff; r_in = r_ff; x_in = x_ff; y_in = y_ff; n_in = n_ff;
      side_in = side_ff; q_in = q_ff;
      dq_in = dq_ff; dd_in = dd_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      prod_in = prod_ff; fin_in = fin_ff;
      out_v_in = out_v_ff && rsp_stall;
      o_l_in = o_l_ff; o_x_in = o_x_ff; o_r_in = o_r_ff; o_y_in = o_y_ff;
      o_e_in = o_e_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               if (m_w == '0 || a_w >= m_w || n_w == '0) begin
                  o_l_in = '0; o_x_in = '0; o_r_in = '0; o_y_in = '0;
                  o_e_in = 1'b1; out_v_in = 1'b1;
               end else begin
                  l_in = a_w; r_in = m_w - a_w; x_in = W'(1); y_in = W'(1);
                  n_in = n_w; side_in = 1'b0;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            // zero test then launch q = big / lesser
            if (lesser == '0) begin
               if (side_ff) begin l_in = '0; x_in = y_ff; end
               else begin r_in = '0; y_in = x_ff; end
               state_in = ST_DONE;
            end else begin
               dq_in = big; dd_in = lesser; rem_in = '0; cnt_in = CW'(W);
               sel_in = DV_Q; state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CW'(1);
               if (!trial[W]) begin
                  rem_in = {1'b0, trial[W-1:0]};
                  dq_in  = {dq_ff[W-2:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[W-1:0], dq_ff[W-1]};
                  dq_in  = {dq_ff[W-2:0], 1'b0};
               end
            end else if (sel_ff == DV_Q) begin
               // cap = (n - bigi) / smalli
               q_in = dq_ff;
               dq_in = n_ff - bigi; dd_in = smalli; rem_in = '0;
               cnt_in = CW'(W); sel_in = DV_CAP;
            end else begin
               prod_in = {{W{1'b0}}, qeff} * {{W{1'b0}}, lesser};
               fin_in = capped;
               q_in = qeff;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (side_ff) begin
               l_in = l_ff - prod_ff[W-1:0];
               x_in = x_ff + W'({{W{1'b0}}, q_ff} * {{W{1'b0}}, y_ff});
            end else begin
               r_in = r_ff - prod_ff[W-1:0];
               y_in = y_ff + W'({{W{1'b0}}, q_ff} * {{W{1'b0}}, x_ff});
            end
            side_in = !side_ff;
            state_in = fin_ff ? ST_DONE : ST_STEP;
         end
         ST_DONE: begin
            o_l_in = l_ff; o_x_in = x_ff; o_r_in = r_ff; o_y_in = y_ff;
            o_e_in = 1'b0; out_v_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         sel_ff   <= DV_Q;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         sel_ff   <= sel_in;
      end
      l_ff <= l_in; r_ff <= r_in; x_ff <= x_in; y_ff <= y_in; n_ff <= n_in;
      side_ff <= side_in; q_ff <= q_in;
      dq_ff <= dq_in; dd_ff <= dd_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      prod_ff <= prod_in; fin_ff <= fin_in;
      o_l_ff <= o_l_in; o_x_ff <= o_x_in; o_r_ff <= o_r_in; o_y_ff <= o_y_in;
      o_e_ff <= o_e_in;
   end

endmodule

>>> rtl/mmmr_checker.sv
module mmmr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_min_forward_rem,
   input logic [31:0] rsp_forward_index,
   input logic        rsp_input_error
);
   // a waiting response stays valid and keeps its forward remainder
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_min_forward_rem))
      else $error("stalled response changed");
   // no new request while a response waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");
   // error responses carry a zero forward index
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_input_error |-> rsp_forward_index == 32'd0)
      else $error("error response with nonzero index");
   // a good response has an index of at least one
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_input_error |-> rsp_forward_index != 32'd0)
      else $error("zero index on good response");
endmodule

bind min_modular_multiple_range_unit mmmr_checker u_mmmr_checker (.*);

>>> tb/tb_top.sv
module tb_top;

   localparam int LIMIT = 20000000;

   typedef struct packed {
      logic [31:0] fwd_rem;
      logic [31:0] fwd_idx;
      logic [31:0] bwd_rem;
      logic [31:0] bwd_idx;
      logic        err;
   } minima_type;

   typedef struct {
      logic [31:0] m;
      logic [31:0] a;
      logic [31:0] n;
      bit          typed;
      minima_type  want;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_modulus = 0;
   logic [31:0] req_multiplier = 0;
   logic [31:0] req_span = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_min_forward_rem;
   logic [31:0] rsp_forward_index;
   logic [31:0] rsp_min_backward_rem;
   logic [31:0] rsp_backward_index;
   logic        rsp_input_error;

   minima_type pending_minima[$];
   int         fail_count = 0;
   int         cycle_count = 0;
   int         stall_left = 0;
   bit         quiet = 0;

   min_modular_multiple_range_unit dut (.*);

   always #6 clock = ~clock;

   function automatic minima_type predict_minima(logic [31:0] m, logic [31:0] a,
                                                 logic [31:0] n);
      longint unsigned l, r, x, y, q, cap, nn;
      minima_type p;
      p = '0;
      if (m == 32'd0 || a >= m || n == 32'd0) begin
         p.err = 1'b1;
         return p;
      end
      l = 64'(a); r = 64'(m) - 64'(a); x = 64'd1; y = 64'd1; nn = 64'(n);
      while (1) begin
         if (l == 0) begin r = 0; y = x; break; end
         q = r / l;
         cap = (nn - y) / x;
         if (q > cap) begin r -= cap * l; y += cap * x; break; end
         r -= q * l;
         y += q * x;
         if (r == 0) begin l = 0; x = y; break; end
         q = l / r;
         cap = (nn - x) / y;
         if (q > cap) begin l -= cap * r; x += cap * y; break; end
         l -= q * r;
         x += q * y;
      end
      p.fwd_rem = l[31:0];
      p.fwd_idx = x[31:0];
      p.bwd_rem = r[31:0];
      p.bwd_idx = y[31:0];
      return p;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: compare against the oldest pending request
   always @(posedge clock) begin
      minima_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_minima.size() == 0) begin
            report("unexpected result", rsp_min_forward_rem, 32'd0);
         end else begin
            w = pending_minima.pop_front();
            if (rsp_min_forward_rem !== w.fwd_rem)
               report("fwd_rem", rsp_min_forward_rem, w.fwd_rem);
            if (rsp_forward_index !== w.fwd_idx)
               report("fwd_idx", rsp_forward_index, w.fwd_idx);
            if (rsp_min_backward_rem !== w.bwd_rem)
               report("bwd_rem", rsp_min_backward_rem, w.bwd_rem);
            if (rsp_backward_index !== w.bwd_idx)
               report("bwd_idx", rsp_backward_index, w.bwd_idx);
            if (rsp_input_error !== w.err)
               report("input_error", {31'd0, rsp_input_error}, {31'd0, w.err});
         end
         stall_left = quiet ? 0 : $urandom_range(0, 13);
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left--;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send_request(logic [31:0] m, logic [31:0] a, logic [31:0] n, bit typed,
                               minima_type want);
      int gap;
      minima_type p;
      gap = quiet ? 0 : $urandom_range(0, 13);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_modulus <= m;
      req_multiplier <= a;
      req_span <= n;
      do @(posedge clock); while (req_stall);
      p = predict_minima(m, a, n);
      if (typed && p !== want) begin
         $display("table row disagrees with prediction for m=%h a=%h n=%h", m, a, n);
         fail_count++;
      end
      pending_minima.push_back(typed ? want : p);
   endtask

   row_type rows[$];

   function automatic row_type mk(logic [31:0] m, logic [31:0] a, logic [31:0] n, bit typed,
                                  minima_type want);
      row_type t;
      t.m = m; t.a = a; t.n = n; t.typed = typed; t.want = want;
      return t;
   endfunction

   initial begin
      minima_type bad, zero_mult;
      logic [31:0] m, a, n;
      int kind;
      bad = '0; bad.err = 1'b1;
      zero_mult = '0; zero_mult.fwd_idx = 32'd1; zero_mult.bwd_idx = 32'd1;

      // bad input
      rows.push_back(mk(32'h0, 32'h0, 32'h5, 1, bad));
      rows.push_back(mk(32'h5, 32'h5, 32'h5, 1, bad));
      rows.push_back(mk(32'h3, 32'hFFFFFFFF, 32'h7, 1, bad));
      rows.push_back(mk(32'h9, 32'h2, 32'h0, 1, bad));
      rows.push_back(mk(32'h0, 32'hFFFFFFFF, 32'h0, 1, bad));
      // zero multiplier
      rows.push_back(mk(32'h1, 32'h0, 32'h1, 1, zero_mult));
      rows.push_back(mk(32'h7, 32'h0, 32'h5, 1, zero_mult));
      rows.push_back(mk(32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 1, zero_mult));
      // extremes and gap reaching zero
      rows.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 0, '0));
      rows.push_back(mk(32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 0, '0));
      rows.push_back(mk(32'hFFFFFFFF, 32'h1, 32'h1, 0, '0));
      rows.push_back(mk(32'h2, 32'h1, 32'h1, 0, '0));
      rows.push_back(mk(32'h6, 32'h2, 32'hA, 0, '0));
      rows.push_back(mk(32'h6, 32'h4, 32'hA, 0, '0));
      rows.push_back(mk(32'hFFFFFFFF, 32'h9E3779B9, 32'hFFFFFFFF, 0, '0));
      rows.push_back(mk(32'hB504F333, 32'h5A827999, 32'h00010000, 0, '0));
      rows.push_back(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, '0));
      rows.push_back(mk(32'h1000, 32'h800, 32'h1, 0, '0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (rows[i])
         send_request(rows[i].m, rows[i].a, rows[i].n, rows[i].typed, rows[i].want);

      for (int i = 0; i < 550; i++) begin
         if (i % 120 == 60) quiet = 1;
         if (i % 120 == 90) quiet = 0;
         if (i == 200) begin
            // hold off until every pending result has come back
            @(negedge clock);
            req_valid <= 0;
            wait (pending_minima.size() == 0);
         end
         kind = $urandom_range(0, 19);
         m = (kind < 6) ? $urandom_range(1, 1000) : $urandom;
         if (m == 0) m = 1;
         a = $urandom % m;
         if (kind == 7) a = 0;
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 200) : $urandom;
         if (n == 0) n = 1;
         if (kind == 19) begin
            m = $urandom;
            a = $urandom;
            n = $urandom_range(0, 1) ? 0 : $urandom;
         end
         send_request(m, a, n, 0, '0);
      end
      @(negedge clock);
      req_valid <= 0;
      quiet = 0;
      wait (pending_minima.size() == 0);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_minima.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
